/* sv/tws_pkg.sv */
// shared types and constants for the three-wire serial transaction master
package tws_pkg;

   localparam int BYTE_W  = 8;
   localparam int HALF_W  = 16;
   localparam int SHIFT_W = 16;
   localparam int COUNT_W = 5;

   // reset value of the half-period register
   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd10;

   // bit counts that open the receive window and close the whole frame
   localparam logic [COUNT_W-1:0] BYTE_BITS  = 5'd8;
   localparam logic [COUNT_W-1:0] FRAME_BITS = 5'd16;

   // transaction opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_CE_LOW   = 4'd1,
      PH_CLK_LOW  = 4'd2,
      PH_CE_HIGH  = 4'd3,
      PH_BIT_LOW  = 4'd4,
      PH_BIT_HIGH = 4'd5,
      PH_END_LOW  = 4'd6,
      PH_END_HIGH = 4'd7
   } phase_type;

   typedef struct packed {
      logic              start_req;
      logic              opcode;
      logic [BYTE_W-1:0] command_byte;
      logic [BYTE_W-1:0] write_data;
      logic              data_pin_in;
   } req_payload_type;

   typedef struct packed {
      logic              serial_clock;
      logic              data_pin_out;
      logic              data_pin_drive;
      logic              chip_enable;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_data;
   } rsp_payload_type;

endpackage

/* sv/tws_channels.sv */
// valid/ready channel interfaces for tick requests and pin-level results
interface tws_req_if;
   import tws_pkg::*;
   logic              valid;
   logic              ready;
   logic              start_req;
   logic              opcode;
   logic [BYTE_W-1:0] command_byte;
   logic [BYTE_W-1:0] write_data;
   logic              data_pin_in;

   modport source (output valid, output start_req, output opcode, output command_byte,
                   output write_data, output data_pin_in, input ready);
   modport sink (input valid, input start_req, input opcode, input command_byte,
                 input write_data, input data_pin_in, output ready);
endinterface

interface tws_rsp_if;
   import tws_pkg::*;
   logic              valid;
   logic              ready;
   logic              serial_clock;
   logic              data_pin_out;
   logic              data_pin_drive;
   logic              chip_enable;
   logic              busy_res;
   logic              done_res;
   logic [BYTE_W-1:0] read_data;

   modport source (output valid, output serial_clock, output data_pin_out,
                   output data_pin_drive, output chip_enable, output busy_res,
                   output done_res, output read_data, input ready);
   modport sink (input valid, input serial_clock, input data_pin_out,
                 input data_pin_drive, input chip_enable, input busy_res,
                 input done_res, input read_data, output ready);
endinterface

/* sv/tws_core.sv */
// phase sequencer, tick timer and shift registers of the serial master
module tws_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  tws_pkg::req_payload_type      req_data,
   input  logic [tws_pkg::HALF_W-1:0]    half_period,
   output tws_pkg::rsp_payload_type      rsp_data
);
   import tws_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [COUNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [SHIFT_W-1:0]  tx_shift_ff, tx_shift_in;
   logic [BYTE_W-1:0]   rx_shift_ff, rx_shift_in;
   logic [HALF_W-1:0]   tick_ff, tick_in;
   logic                is_read_ff, is_read_in;
   logic                clock_ff, clock_in;
   logic                enable_ff, enable_in;
   logic                drive_ff, drive_in;

   logic [HALF_W-1:0]   hold;
   logic [HALF_W:0]     tick_next_wide;
   logic                tick_expire;
   logic [COUNT_W-1:0]  bit_count_inc;
   logic                done;

   // phase timer: a zero half period counts as one tick
   assign hold           = (half_period == '0) ? HALF_W'(1) : half_period;
   assign tick_next_wide = {1'b0, tick_ff} + (HALF_W + 1)'(1);
   assign tick_expire    = tick_next_wide >= {1'b0, hold};
   assign bit_count_inc  = bit_count_ff + COUNT_W'(1);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (req_data.start_req) phase_in = PH_CE_LOW;
         end
         PH_CE_LOW: begin
            if (tick_expire) phase_in = PH_CLK_LOW;
         end
         PH_CLK_LOW: begin
            if (tick_expire) phase_in = PH_CE_HIGH;
         end
         PH_CE_HIGH: begin
            if (tick_expire) phase_in = PH_BIT_LOW;
         end
         PH_BIT_LOW: begin
            if (tick_expire) phase_in = PH_BIT_HIGH;
         end
         PH_BIT_HIGH: begin
            if (tick_expire) phase_in = (bit_count_inc >= FRAME_BITS) ? PH_END_LOW : PH_BIT_LOW;
         end
         PH_END_LOW: begin
            if (tick_expire) phase_in = PH_END_HIGH;
         end
         PH_END_HIGH: begin
            if (tick_expire) phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // counters, shift registers and pin levels
   always_comb begin
      bit_count_in = bit_count_ff;
      tx_shift_in  = tx_shift_ff;
      rx_shift_in  = rx_shift_ff;
      tick_in      = tick_ff;
      is_read_in   = is_read_ff;
      clock_in     = clock_ff;
      enable_in    = enable_ff;
      drive_in     = drive_ff;
      if (phase_ff == PH_IDLE) begin
         // latch a new transaction
         if (req_data.start_req) begin
            is_read_in   = req_data.opcode;
            tx_shift_in  = (req_data.opcode == OP_READ) ?
                           {BYTE_W'(0), req_data.command_byte} :
                           {req_data.write_data, req_data.command_byte};
            bit_count_in = '0;
            tick_in      = '0;
            enable_in    = 1'b0;
         end
      end else if (!tick_expire) begin
         tick_in = tick_next_wide[HALF_W-1:0];
      end else begin
         tick_in = '0;
         case (phase_ff)
            PH_CE_LOW: begin
               clock_in = 1'b0;
            end
            PH_CLK_LOW: begin
               enable_in = 1'b1;
            end
            PH_CE_HIGH: begin
               bit_count_in = '0;
               clock_in     = 1'b0;
               drive_in     = 1'b1;
            end
            PH_BIT_LOW: begin
               // sample the pin into the top bit before the rising edge
               if (is_read_ff && (bit_count_ff >= BYTE_BITS))
                  rx_shift_in = {req_data.data_pin_in, rx_shift_ff[BYTE_W-1:1]};
               clock_in = 1'b1;
            end
            PH_BIT_HIGH: begin
               tx_shift_in  = {1'b0, tx_shift_ff[SHIFT_W-1:1]};
               bit_count_in = bit_count_inc;
               clock_in     = 1'b0;
               if (bit_count_inc < FRAME_BITS)
                  drive_in = !(is_read_ff && (bit_count_inc >= BYTE_BITS));
            end
            PH_END_LOW: begin
               clock_in = 1'b1;
            end
            PH_END_HIGH: begin
               enable_in = 1'b0;
               drive_in  = 1'b1;
            end
            default: begin
               tick_in = tick_ff;
            end
         endcase
      end
   end

   // result fields show the state after this tick
   always_comb begin
      done                    = (phase_ff == PH_END_HIGH) && tick_expire;
      rsp_data.serial_clock   = clock_in;
      rsp_data.data_pin_out   = drive_in & tx_shift_in[0];
      rsp_data.data_pin_drive = drive_in;
      rsp_data.chip_enable    = enable_in;
      rsp_data.busy_res       = (phase_in != PH_IDLE);
      rsp_data.done_res       = done;
      rsp_data.read_data      = rx_shift_in;
   end

   // state registers advance once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         tx_shift_ff  <= '0;
         rx_shift_ff  <= '0;
         tick_ff      <= '0;
         is_read_ff   <= 1'b0;
         clock_ff     <= 1'b0;
         enable_ff    <= 1'b0;
         drive_ff     <= 1'b1;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         tx_shift_ff  <= tx_shift_in;
         rx_shift_ff  <= rx_shift_in;
         tick_ff      <= tick_in;
         is_read_ff   <= is_read_in;
         clock_ff     <= clock_in;
         enable_ff    <= enable_in;
         drive_ff     <= drive_in;
      end
   end

   // the frame closes with chip enable low and the block idle
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && (phase_ff == PH_END_HIGH) && tick_expire
      |=> (phase_ff == PH_IDLE) && !enable_ff && drive_ff)
      else $error("frame end did not return to idle");

   // the line is released only inside a read transaction
   a_release_in_read: assert property (@(posedge clock) disable iff (reset)
      !drive_ff |-> is_read_ff && (phase_ff != PH_IDLE))
      else $error("data line released outside a read");

   // chip enable is only asserted while a transaction runs
   a_enable_busy: assert property (@(posedge clock) disable iff (reset)
      enable_ff |-> (phase_ff != PH_IDLE))
      else $error("chip enable high while idle");

   // no tick, no state change
   a_hold_without_tick: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff) && $stable(tick_ff) && $stable(bit_count_ff))
      else $error("state moved without a tick");

endmodule

/* sv/three_wire_serial_transaction_master.sv */
// top level: request register, sequencer core and result register
//
//  channel  | direction | transfer
//  ---------+-----------+-------------------------------------------------
//  req_bus  | in        | one tick: start, opcode, command, data, pin level
//  rsp_bus  | out       | pin levels, busy, done, read byte after the tick
//  csr_*    | in        | half-period tick count, written when enable high
//
// A new request transfer is taken every cycle while the result is not stalled.
// A request transfer is held in the request register, and its result is captured
// and offered from the result register (request register, then result register).
// Reset is synchronous and clears all control state; half period returns to HALF_PERIOD_RESET.
// A stalled result holds the core and the request register; request ready
// then drops once the request register is full.
module three_wire_serial_transaction_master (
   input  logic                         clock,
   input  logic                         reset,
   tws_req_if.sink                      req_bus,
   tws_rsp_if.source                    rsp_bus,
   input  logic                         csr_write_enable,
   input  logic [tws_pkg::HALF_W-1:0]   csr_write_data
);
   import tws_pkg::*;

   logic              in_valid_ff, in_valid_in;
   req_payload_type   in_data_ff;
   req_payload_type   req_data;
   logic              out_valid_ff, out_valid_in;
   rsp_payload_type   out_data_ff;
   rsp_payload_type   core_rsp;
   logic [HALF_W-1:0] half_period_ff;
   logic              step_en;
   logic              req_take;

   // request payload from the channel
   always_comb begin
      req_data.start_req    = req_bus.start_req;
      req_data.opcode       = req_bus.opcode;
      req_data.command_byte = req_bus.command_byte;
      req_data.write_data   = req_bus.write_data;
      req_data.data_pin_in  = req_bus.data_pin_in;
   end

   // handshake control
   assign step_en       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || step_en;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign in_valid_in   = req_take ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign out_valid_in  = step_en ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_write_enable) begin
         half_period_ff <= csr_write_data;
      end
   end

   tws_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .req_data    (in_data_ff),
      .half_period (half_period_ff),
      .rsp_data    (core_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_data_ff <= core_rsp;
      end
   end

   // result channel
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.serial_clock   = out_data_ff.serial_clock;
   assign rsp_bus.data_pin_out   = out_data_ff.data_pin_out;
   assign rsp_bus.data_pin_drive = out_data_ff.data_pin_drive;
   assign rsp_bus.chip_enable    = out_data_ff.chip_enable;
   assign rsp_bus.busy_res       = out_data_ff.busy_res;
   assign rsp_bus.done_res       = out_data_ff.done_res;
   assign rsp_bus.read_data      = out_data_ff.read_data;

endmodule
